// ----- sv/tgs_pkg.sv -----
// Shared constants, codes and helpers for the triangle gradient setup block.
`timescale 1ns / 1ps
package tgs_pkg;
	typedef logic [47:0] q48_t;

	localparam int OUT_FRAC_BITS_DEF = 16;

	// Vertex slot codes
	localparam logic [1:0] SLOT_MIN  = 2'd0;
	localparam logic [1:0] SLOT_MID  = 2'd1;
	localparam logic [1:0] SLOT_MAX  = 2'd2;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	// Attribute codes
	localparam logic [1:0] ATTR_U   = 2'd0;
	localparam logic [1:0] ATTR_V   = 2'd1;
	localparam logic [1:0] ATTR_ONE = 2'd2;

	localparam q48_t MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam q48_t MIN48 = 48'h8000_0000_0000;

	// Apply a sign to a magnitude and clamp to the signed 48-bit range.
	function automatic q48_t sat48(input logic [63:0] mag, input logic neg);
		q48_t r;
		if (neg) begin
			if (mag > {16'd0, MIN48}) r = MIN48;
			else r = q48_t'(48'd0 - mag[47:0]);
		end else begin
			if (mag > {16'd0, MAX48}) r = MAX48;
			else r = mag[47:0];
		end
		return r;
	endfunction
endpackage

// ----- sv/triangle_gradient_setup_core.sv -----
// Top level: perspective-correct gradient setup with one shared divider and multiplier.
`timescale 1ns / 1ps
// Vertices arrive in min-y, mid-y, max-y order on the input channel. Slots 0 and 1
// are simply stored; slot 2 starts the setup, during which in_stall stays
// high. The setup forms nine reciprocal-style quotients (u/w, v/w, 1/w per vertex),
// the doubled signed area, and for each attribute an x and a y gradient, emitting
// three results (u/w, v/w, 1/w) with last on the third. Every quotient goes through
// one bit-serial restoring divider of 64 steps, so a slot 2 vertex holds the block
// through the nine ratios, the area and the three gradient pairs with their output
// transfers, waiting while out_stall holds a result. Products use one registered
// signed multiplier. A zero w or zero area sets degenerate and forces both steps
// to zero.
module triangle_gradient_setup_core
	import tgs_pkg::*;
#(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         vertex_slot,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        pos_w,
	input  logic [15:0]        tex_u,
	input  logic [15:0]        tex_v,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         attribute,
	output logic signed [47:0] value_min,
	output logic signed [47:0] value_mid,
	output logic signed [47:0] value_max,
	output logic signed [47:0] step_x,
	output logic signed [47:0] step_y,
	output logic               degenerate,
	output logic               last
);
	localparam int VW = 17 + OUT_FRAC_BITS;   // width of one attribute value
	localparam int MA = VW + 1;               // signed difference width
	localparam int PW = MA + 17;              // product width

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDIV  = 4'd1;
	localparam logic [3:0] ST_RWAIT = 4'd2;
	localparam logic [3:0] ST_AREA0 = 4'd3;
	localparam logic [3:0] ST_AREA1 = 4'd4;
	localparam logic [3:0] ST_AREA2 = 4'd5;
	localparam logic [3:0] ST_GX0   = 4'd6;
	localparam logic [3:0] ST_GX1   = 4'd7;
	localparam logic [3:0] ST_GX2   = 4'd8;
	localparam logic [3:0] ST_GXW   = 4'd9;
	localparam logic [3:0] ST_GY0   = 4'd10;
	localparam logic [3:0] ST_GY1   = 4'd11;
	localparam logic [3:0] ST_GY2   = 4'd12;
	localparam logic [3:0] ST_GYW   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	localparam logic [6:0] DIV_STEPS = 7'd64;

	logic [3:0] state_q;
	logic [1:0] vi_q, ai_q, k_q;

	logic [15:0] x_q [3];
	logic [15:0] y_q [3];
	logic [31:0] w_q [3];
	logic [15:0] u_q [3];
	logic [15:0] v_q [3];

	// attribute-major chain: entry 3*a+v; the current attribute sits in 0..2
	logic [VW-1:0] val_q [9];

	logic signed [36:0] area_q;
	logic               degen_q;
	logic signed [63:0] acc_q;
	logic signed [PW-1:0] prod_s1;
	logic               neg_q;
	q48_t               sx_q, sy_q;

	// divider
	logic [63:0] dq_q;
	logic [40:0] drem_q;
	logic [39:0] dsr_q;
	logic [6:0]  dcnt_q;
	logic        div_start;
	logic [63:0] div_dvd;
	logic [39:0] div_dsr;
	logic [40:0] rs;
	logic [41:0] trial;
	logic        ge;

	logic signed [16:0] dx0, dx1, dy0, dy1;
	logic signed [MA-1:0] da0, da1;
	logic signed [MA-1:0] mul_a;
	logic signed [16:0]   mul_b;
	logic signed [63:0]   prod_ext, num;
	logic [63:0]          num_mag;
	logic [39:0]          area_mag;
	logic [16:0]          tval;
	logic                 in_xfer, out_xfer;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_xfer  = out_valid && !out_stall;

	// Edge deltas against the max-y vertex
	assign dx0 = 17'(signed'({x_q[0][15], x_q[0]}) - signed'({x_q[2][15], x_q[2]}));
	assign dx1 = 17'(signed'({x_q[1][15], x_q[1]}) - signed'({x_q[2][15], x_q[2]}));
	assign dy0 = 17'(signed'({y_q[0][15], y_q[0]}) - signed'({y_q[2][15], y_q[2]}));
	assign dy1 = 17'(signed'({y_q[1][15], y_q[1]}) - signed'({y_q[2][15], y_q[2]}));
	assign da0 = MA'(signed'({1'b0, val_q[0]}) - signed'({1'b0, val_q[2]}));
	assign da1 = MA'(signed'({1'b0, val_q[1]}) - signed'({1'b0, val_q[2]}));

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_AREA0: begin mul_a = MA'(dx1); mul_b = dy0; end
			ST_AREA1: begin mul_a = MA'(dx0); mul_b = dy1; end
			ST_GX0:   begin mul_a = da1;      mul_b = dy0; end
			ST_GX1:   begin mul_a = da0;      mul_b = dy1; end
			ST_GY0:   begin mul_a = da1;      mul_b = dx0; end
			ST_GY1:   begin mul_a = da0;      mul_b = dx1; end
			default:  begin mul_a = '0;       mul_b = '0;  end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(mul_a * mul_b);
	end

	assign prod_ext = 64'(prod_s1);
	assign num      = (acc_q - prod_ext) <<< 4;
	assign num_mag  = num[63] ? 64'(64'd0 - num) : num;
	assign area_mag = area_q[36] ? 40'(40'd0 - 40'(area_q)) : 40'(area_q);

	// Ratio numerator for the current attribute
	always_comb begin
		case (ai_q)
			ATTR_U:   tval = {1'b0, u_q[vi_q]};
			ATTR_V:   tval = {1'b0, v_q[vi_q]};
			default:  tval = 17'h10000;
		endcase
	end

	// Divider launch
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		case (state_q)
			ST_RDIV: begin
				div_start = 1'b1;
				div_dvd   = {{(64 - VW){1'b0}}, tval, {OUT_FRAC_BITS{1'b0}}};
				div_dsr   = {8'd0, w_q[vi_q]};
			end
			ST_GX2, ST_GY2: begin
				div_start = !degen_q;
				div_dvd   = num_mag;
				div_dsr   = area_mag;
			end
			default: div_start = 1'b0;
		endcase
	end

	// Restoring divide step
	assign rs    = {drem_q[39:0], dq_q[63]};
	assign trial = {1'b0, rs} - {2'b00, dsr_q};
	assign ge    = !trial[41];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_start) begin
			dcnt_q <= DIV_STEPS;
		end else if (dcnt_q != 7'd0) begin
			dcnt_q <= dcnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dq_q   <= div_dvd;
			drem_q <= '0;
			dsr_q  <= div_dsr;
		end else if (dcnt_q != 7'd0) begin
			dq_q   <= {dq_q[62:0], ge};
			drem_q <= ge ? trial[40:0] : rs;
		end
	end

	// Store vertices
	always_ff @(posedge clk) begin
		if (in_xfer && vertex_slot != SLOT_NONE) begin
			x_q[vertex_slot] <= pos_x;
			y_q[vertex_slot] <= pos_y;
			w_q[vertex_slot] <= pos_w;
			u_q[vertex_slot] <= tex_u;
			v_q[vertex_slot] <= tex_v;
		end
	end

	// Attribute value chain
	always_ff @(posedge clk) begin
		if (state_q == ST_RWAIT && dcnt_q == 7'd0) begin
			for (int i = 0; i < 8; i++) val_q[i] <= val_q[i + 1];
			val_q[8] <= (w_q[vi_q] == 32'd0) ? '0 : dq_q[VW-1:0];
		end else if (out_xfer) begin
			for (int i = 0; i < 6; i++) val_q[i] <= val_q[i + 3];
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_AREA1, ST_GX1, ST_GY1: acc_q <= prod_ext;
			ST_AREA2: begin
				area_q  <= 37'(acc_q - prod_ext);
				degen_q <= (w_q[0] == 32'd0) || (w_q[1] == 32'd0) || (w_q[2] == 32'd0)
					|| ((acc_q - prod_ext) == 64'sd0);
			end
			ST_GX2, ST_GY2: begin
				neg_q <= num[63] ^ area_q[36];
				if (degen_q) begin
					if (state_q == ST_GX2) sx_q <= '0;
					else sy_q <= '0;
				end
			end
			ST_GXW: if (dcnt_q == 7'd0) sx_q <= sat48(dq_q, neg_q);
			ST_GYW: if (dcnt_q == 7'd0) sy_q <= sat48(dq_q, !neg_q);
			default: acc_q <= acc_q;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vi_q    <= '0;
			ai_q    <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && vertex_slot == SLOT_MAX) begin
						state_q <= ST_RDIV;
						vi_q    <= SLOT_MIN;
						ai_q    <= ATTR_U;
					end
				end
				ST_RDIV: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (dcnt_q == 7'd0) begin
						if (vi_q == SLOT_MAX) begin
							vi_q <= SLOT_MIN;
							if (ai_q == ATTR_ONE) begin
								state_q <= ST_AREA0;
							end else begin
								ai_q    <= ai_q + 2'd1;
								state_q <= ST_RDIV;
							end
						end else begin
							vi_q    <= vi_q + 2'd1;
							state_q <= ST_RDIV;
						end
					end
				end
				ST_AREA0: state_q <= ST_AREA1;
				ST_AREA1: state_q <= ST_AREA2;
				ST_AREA2: begin
					state_q <= ST_GX0;
					k_q     <= ATTR_U;
				end
				ST_GX0: state_q <= ST_GX1;
				ST_GX1: state_q <= ST_GX2;
				ST_GX2: state_q <= degen_q ? ST_GY0 : ST_GXW;
				ST_GXW: if (dcnt_q == 7'd0) state_q <= ST_GY0;
				ST_GY0: state_q <= ST_GY1;
				ST_GY1: state_q <= ST_GY2;
				ST_GY2: state_q <= degen_q ? ST_OUT : ST_GYW;
				ST_GYW: if (dcnt_q == 7'd0) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_xfer) begin
						if (k_q == ATTR_ONE) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_GX0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result fields
	assign attribute  = k_q;
	assign value_min  = {{(48 - VW){1'b0}}, val_q[0]};
	assign value_mid  = {{(48 - VW){1'b0}}, val_q[1]};
	assign value_max  = {{(48 - VW){1'b0}}, val_q[2]};
	assign step_x     = sx_q;
	assign step_y     = sy_q;
	assign degenerate = degen_q;
	assign last       = (k_q == ATTR_ONE);

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> (step_x == '0) && (step_y == '0))
		else $error("degenerate result with nonzero step");
	a_last_attr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> attribute == ATTR_ONE)
		else $error("last flag on wrong attribute");
	a_setup_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && vertex_slot == SLOT_MAX |=> in_stall && !out_valid)
		else $error("setup did not start");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DIV_STEPS)
		else $error("divider count out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(attribute))
		else $error("result dropped while stalled");
`endif
endmodule

// ----- test/tgs_checker.sv -----
// Checker for the gradient setup block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module tgs_checker
	import tgs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         vertex_slot,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        pos_w,
	input  logic [15:0]        tex_u,
	input  logic [15:0]        tex_v,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         attribute,
	input  logic signed [47:0] value_min,
	input  logic signed [47:0] value_mid,
	input  logic signed [47:0] value_max,
	input  logic signed [47:0] step_x,
	input  logic signed [47:0] step_y,
	input  logic               degenerate,
	input  logic               last,
	output int                 fail_count,
	output int                 pending_count
);
	localparam int FRAC = OUT_FRAC_BITS_DEF;

	typedef struct packed {
		logic [1:0]  attr;
		logic [47:0] vmin;
		logic [47:0] vmid;
		logic [47:0] vmax;
		logic [47:0] sx;
		logic [47:0] sy;
		logic        degen;
		logic        fin;
	} gradient_t;

	gradient_t gradient_q[$];

	// Stored min-y and mid-y vertices
	logic signed [15:0] vx [2];
	logic signed [15:0] vy [2];
	logic [31:0]        vw [2];
	logic [15:0]        vu [2];
	logic [15:0]        vv [2];

	initial fail_count = 0;
	assign pending_count = gradient_q.size();

	task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic logic [47:0] clamp48(input longint v);
		if (v > longint'(MAX48)) return MAX48;
		if (v < -longint'(MAX48) - 1) return MIN48;
		return v[47:0];
	endfunction

	// Floored t * 2^F / w, zero for zero w
	function automatic longint quotient(input longint t, input logic [31:0] w);
		if (w == 32'd0) return longint'(0);
		return (t <<< FRAC) / longint'({32'd0, w});
	endfunction

	// Form the three attribute gradients for the triangle closed by vertex 2
	task automatic predict_gradients(input logic signed [15:0] x2, input logic signed [15:0] y2,
			input logic [31:0] w2, input logic [15:0] u2, input logic [15:0] v2);
		longint xs[3], ys[3], val[3][3];
		logic [31:0] ws[3];
		longint tu[3], tv[3];
		longint area, dx0, dx1, dy0, dy1, da0, da1, nx, ny, sx, sy;
		logic degen;
		gradient_t g;
		for (int i = 0; i < 2; i++) begin
			xs[i] = longint'(vx[i]); ys[i] = longint'(vy[i]); ws[i] = vw[i];
			tu[i] = longint'(vu[i]); tv[i] = longint'(vv[i]);
		end
		xs[2] = longint'(x2); ys[2] = longint'(y2); ws[2] = w2;
		tu[2] = longint'(u2); tv[2] = longint'(v2);
		degen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (ws[i] == 32'd0) degen = 1'b1;
			val[0][i] = quotient(tu[i], ws[i]);
			val[1][i] = quotient(tv[i], ws[i]);
			val[2][i] = quotient(longint'(1) <<< 16, ws[i]);
		end
		dx0 = xs[0] - xs[2];
		dx1 = xs[1] - xs[2];
		dy0 = ys[0] - ys[2];
		dy1 = ys[1] - ys[2];
		area = dx1 * dy0 - dx0 * dy1;
		if (area == 0) degen = 1'b1;
		for (int k = 0; k < 3; k++) begin
			sx = 0;
			sy = 0;
			if (!degen) begin
				da0 = val[k][0] - val[k][2];
				da1 = val[k][1] - val[k][2];
				nx = (da1 * dy0 - da0 * dy1) * 16;
				ny = (da1 * dx0 - da0 * dx1) * 16;
				sx = nx / area;
				sy = -(ny / area);
			end
			g.attr  = (k == 0) ? ATTR_U : (k == 1) ? ATTR_V : ATTR_ONE;
			g.vmin  = clamp48(val[k][0]);
			g.vmid  = clamp48(val[k][1]);
			g.vmax  = clamp48(val[k][2]);
			g.sx    = clamp48(sx);
			g.sy    = clamp48(sy);
			g.degen = degen;
			g.fin   = (k == 2);
			gradient_q.push_back(g);
		end
	endtask

	// Track input transfers
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (vertex_slot == SLOT_MIN || vertex_slot == SLOT_MID) begin
				vx[vertex_slot[0]] = pos_x;
				vy[vertex_slot[0]] = pos_y;
				vw[vertex_slot[0]] = pos_w;
				vu[vertex_slot[0]] = tex_u;
				vv[vertex_slot[0]] = tex_v;
			end else if (vertex_slot == SLOT_MAX) begin
				predict_gradients(pos_x, pos_y, pos_w, tex_u, tex_v);
			end
		end
	end

	// Compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		gradient_t g;
		if (arst_n && out_valid && !out_stall) begin
			if (gradient_q.size() == 0) begin
				report("unexpected result", 48'(attribute), 48'd0);
			end else begin
				g = gradient_q.pop_front();
				if (attribute !== g.attr) report("attribute", 48'(attribute), 48'(g.attr));
				if (value_min !== g.vmin) report("value_min", value_min, g.vmin);
				if (value_mid !== g.vmid) report("value_mid", value_mid, g.vmid);
				if (value_max !== g.vmax) report("value_max", value_max, g.vmax);
				if (step_x !== g.sx) report("step_x", step_x, g.sx);
				if (step_y !== g.sy) report("step_y", step_y, g.sy);
				if (degenerate !== g.degen)
					report("degenerate", 48'(degenerate), 48'(g.degen));
				if (last !== g.fin) report("last", 48'(last), 48'(g.fin));
			end
		end
	end
endmodule

// ----- test/tb_triangle_gradient_setup_core.sv -----
// Testbench top: drives vertices and output stalls, gives the verdict.
`timescale 1ns / 1ps
module tb_triangle_gradient_setup_core;
	import tgs_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         vertex_slot;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [31:0]        pos_w;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         attribute;
	logic signed [47:0] value_min;
	logic signed [47:0] value_mid;
	logic signed [47:0] value_max;
	logic signed [47:0] step_x;
	logic signed [47:0] step_y;
	logic               degenerate;
	logic               last;
	int                 fail_count;
	int                 pending_count;

	int burst_left = 0;
	bit sender_gaps = 0;
	int stall_mode = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	triangle_gradient_setup_core dut (.*);

	tgs_checker u_checker (.*);

	initial clk = 0;
	always #2 clk = ~clk;

	// Receiver stall: random, periodic or none, plus long hold-offs on request
	initial begin
		int phase_cnt;
		out_stall = 0;
		phase_cnt = 0;
		forever begin
			@(negedge clk);
			phase_cnt++;
			if (hold_left > 0) begin
				out_stall = 1;
				hold_left--;
			end else begin
				case (stall_mode)
					1: out_stall = ($urandom_range(0, 99) < 40);
					2: out_stall = ((phase_cnt % 7) < 3);
					default: out_stall = 0;
				endcase
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[triangle_gradient_setup_core] ERROR");
			$finish;
		end
	end

	// Offer one vertex, hold until transferred; starts and ends at a falling edge
	task automatic send_vertex(input logic [1:0] slot, input logic [15:0] x,
			input logic [15:0] y, input logic [31:0] w, input logic [15:0] u,
			input logic [15:0] v);
		if (sender_gaps && burst_left == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		in_valid = 1;
		vertex_slot = slot;
		pos_x = x; pos_y = y; pos_w = w; tex_u = u; tex_v = v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		in_valid = 0;
	endtask

	function automatic logic [15:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 255) - 128);
			default: return 16'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	function automatic logic [31:0] rand_w();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return $urandom_range(1, 16);
			2, 3, 4: return $urandom;
			default: return $urandom_range(32'h4000, 32'h40000);
		endcase
	endfunction

	task automatic random_vertex(input logic [1:0] slot);
		send_vertex(slot, rand_pos(), rand_pos(), rand_w(), 16'($urandom), 16'($urandom));
	endtask

	// Well-formed triangle with random content; some collinear
	task automatic random_triangle();
		logic [15:0] x0, y0;
		x0 = rand_pos();
		y0 = rand_pos();
		send_vertex(SLOT_MIN, x0, y0, rand_w(), 16'($urandom), 16'($urandom));
		random_vertex(SLOT_MID);
		if ($urandom_range(0, 15) == 0)
			send_vertex(SLOT_MAX, x0, y0, rand_w(), 16'($urandom), 16'($urandom));
		else
			random_vertex(SLOT_MAX);
	endtask

	task automatic wait_drained();
		while (pending_count != 0) @(negedge clk);
	endtask

	initial begin
		int sent;
		arst_n = 0;
		in_valid = 0;
		vertex_slot = SLOT_MIN;
		pos_x = 0; pos_y = 0; pos_w = 0; tex_u = 0; tex_v = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, zero w, zero area, ignored slot, saturation
		send_vertex(SLOT_MIN, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
		send_vertex(SLOT_MID, 16'h7FFF, 16'h8000, 32'h0001_0000, 16'h0000, 16'hFFFF);
		send_vertex(SLOT_MAX, 16'h0000, 16'h7FFF, 32'h0000_0001, 16'hFFFF, 16'hFFFF);
		send_vertex(SLOT_MIN, 16'h0000, 16'h0000, 32'h0000_0001, 16'hFFFF, 16'hFFFF);
		send_vertex(SLOT_MID, 16'h0001, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
		send_vertex(SLOT_MAX, 16'h0000, 16'h0001, 32'hFFFF_FFFF, 16'h0001, 16'h0001);
		send_vertex(SLOT_MID, 16'h0010, 16'h0020, 32'h0000_0000, 16'h1234, 16'h5678);
		send_vertex(SLOT_MAX, 16'h0040, 16'h0010, 32'h0002_0000, 16'h8000, 16'h4000);
		send_vertex(SLOT_MIN, 16'h0010, 16'h0010, 32'h0001_0000, 16'h1000, 16'h2000);
		send_vertex(SLOT_MID, 16'h0020, 16'h0020, 32'h0001_0000, 16'h3000, 16'h4000);
		send_vertex(SLOT_MAX, 16'h0030, 16'h0030, 32'h0001_0000, 16'h5000, 16'h6000);
		send_vertex(SLOT_NONE, 16'h7FFF, 16'h7FFF, 32'h0, 16'hFFFF, 16'hFFFF);
		send_vertex(SLOT_MID, 16'h0100, 16'h0080, 32'h0003_0000, 16'hAAAA, 16'h5555);
		send_vertex(SLOT_MAX, 16'hFF00, 16'h0200, 32'h0000_8000, 16'h5555, 16'hAAAA);
		send_vertex(SLOT_MAX, 16'h0100, 16'h0080, 32'h0003_0000, 16'hAAAA, 16'h5555);
		sent = 15;

		// Random traffic in phases of idling style
		for (int phase = 0; phase < 6; phase++) begin
			sender_gaps = (phase % 3 != 0);
			stall_mode = phase % 3;
			if (phase == 2) hold_left = 3000;
			while (sent < 15 + (phase + 1) * 70) begin
				case ($urandom_range(0, 9))
					0: begin random_vertex(SLOT_NONE); sent++; end
					1: begin random_vertex(2'($urandom_range(0, 2))); sent++; end
					default: begin random_triangle(); sent += 3; end
				endcase
			end
			if (phase == 3) wait_drained();
		end

		in_valid = 0;
		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("[triangle_gradient_setup_core] OK");
		else
			$display("[triangle_gradient_setup_core] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/tgs_pkg.sv
sv/triangle_gradient_setup_core.sv
test/tgs_checker.sv
test/tb_triangle_gradient_setup_core.sv
